// ===== hdl/byte_budget_admission_fifo_defines.svh =====
// ----------------------------------------------------------------------------
// byte_budget_admission_fifo_defines.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_BUDGET_ADMISSION_FIFO_DEFINES_SVH
`define BYTE_BUDGET_ADMISSION_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BBAF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbaf: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BBAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbaf: next-cycle check failed");

`endif

// ===== hdl/bbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbaf_pkg
// Types, codes and reset values of the byte budget admission FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbaf_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned BYTES_W   = 20;
  localparam int unsigned LIMIT_W   = 5;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD    = 2'd2;

  localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST   = 5'd16;
  localparam logic [BYTES_W-1:0] BYTE_CAPACITY_RST = 20'd65536;
  localparam logic [LEN_W-1:0]   MAX_RECORD_RST    = 16'd16384;

  typedef enum logic [CMD_W-1:0] {
    CMD_POST  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SHAPE = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_CLOSED    = 3'd3,
    ST_FULL      = 3'd4,
    ST_OVER      = 3'd5,
    ST_EMPTY     = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             is_resp;
    logic [LEN_W-1:0] bytes;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // latch the incoming word, fetch the head record
    logic exec;  // run the command, load the result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bbaf_if.sv =====
// ----------------------------------------------------------------------------
// bbaf_if
// Command and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bbaf_in_if ();
  logic                         valid;
  logic                         ready;
  logic [bbaf_pkg::CMD_W-1:0]   command;
  logic                         token_valid;
  logic                         is_response;
  logic [bbaf_pkg::LEN_W-1:0]   frame_bytes;
  logic [bbaf_pkg::TAG_W-1:0]   record_tag;

  modport source (output valid, command, token_valid, is_response, frame_bytes,
                  record_tag, input ready);
  modport sink   (input valid, command, token_valid, is_response, frame_bytes,
                  record_tag, output ready);
endinterface

interface bbaf_out_if #(
  parameter int unsigned CntW = 5
) ();
  logic                         valid;
  logic                         ready;
  logic [bbaf_pkg::STAT_W-1:0]  status;
  logic                         pop_valid;
  logic [bbaf_pkg::TAG_W-1:0]   out_tag;
  logic                         out_is_response;
  logic [bbaf_pkg::LEN_W-1:0]   out_bytes;
  logic                         wake;
  logic [CntW-1:0]              entries_now;
  logic [bbaf_pkg::BYTES_W-1:0] bytes_held;

  modport source (output valid, status, pop_valid, out_tag, out_is_response, out_bytes,
                  wake, entries_now, bytes_held, input ready);
  modport sink   (input valid, status, pop_valid, out_tag, out_is_response, out_bytes,
                  wake, entries_now, bytes_held, output ready);
endinterface

`default_nettype wire

// ===== hdl/bbaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbaf_ctrl
// Sequencer: takes a word, runs it once the result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbaf_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output bbaf_pkg::ctrl_cmd_t        cmd_o
);

  bbaf_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbaf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbaf_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bbaf_pkg::S_EXEC;
      end
      bbaf_pkg::S_EXEC: begin
        if (!out_valid_q || out_ready_i) state_d = bbaf_pkg::S_IDLE;
      end
      default: state_d = bbaf_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.exec   = 1'b0;
    unique case (state_q)
      bbaf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      bbaf_pkg::S_EXEC: begin
        cmd_o.exec = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
    if (cmd_o.exec)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/bbaf_dp.sv =====
// ----------------------------------------------------------------------------
// bbaf_dp
// Record store, pointers, counters, admission checks and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbaf_dp #(
  parameter int unsigned DEPTH = bbaf_pkg::DEPTH_DEF,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bbaf_pkg::ctrl_cmd_t           cmd_i,
  // config
  input  wire logic                          cfg_we_i,
  input  wire logic [bbaf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bbaf_pkg::CFG_W-1:0]    cfg_data_i,
  // incoming word
  input  wire logic [bbaf_pkg::CMD_W-1:0]    command_i,
  input  wire logic                          token_valid_i,
  input  wire logic                          is_response_i,
  input  wire logic [bbaf_pkg::LEN_W-1:0]    frame_bytes_i,
  input  wire logic [bbaf_pkg::TAG_W-1:0]    record_tag_i,
  // result register
  output logic [bbaf_pkg::STAT_W-1:0]        status_o,
  output logic                               pop_valid_o,
  output logic [bbaf_pkg::TAG_W-1:0]         out_tag_o,
  output logic                               out_is_response_o,
  output logic [bbaf_pkg::LEN_W-1:0]         out_bytes_o,
  output logic                               wake_o,
  output logic [CntW-1:0]                    entries_now_o,
  output logic [bbaf_pkg::BYTES_W-1:0]       bytes_held_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW = (CntW > bbaf_pkg::LIMIT_W) ? CntW : bbaf_pkg::LIMIT_W;
  localparam int unsigned BW   = bbaf_pkg::BYTES_W;
  localparam int unsigned LW   = bbaf_pkg::LEN_W;

  // config registers
  logic [bbaf_pkg::LIMIT_W-1:0] entry_limit_q;
  logic [BW-1:0]                byte_capacity_q;
  logic [LW-1:0]                max_record_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit_q   <= bbaf_pkg::ENTRY_LIMIT_RST;
      byte_capacity_q <= bbaf_pkg::BYTE_CAPACITY_RST;
      max_record_q    <= bbaf_pkg::MAX_RECORD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbaf_pkg::CFG_ENTRY_LIMIT:   entry_limit_q   <= cfg_data_i[bbaf_pkg::LIMIT_W-1:0];
        bbaf_pkg::CFG_BYTE_CAPACITY: byte_capacity_q <= cfg_data_i[BW-1:0];
        bbaf_pkg::CFG_MAX_RECORD:    max_record_q    <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // latched word
  logic [bbaf_pkg::CMD_W-1:0] cmd_q;
  logic                       tok_q;
  logic                       resp_q;
  logic [LW-1:0]              len_q;
  logic [bbaf_pkg::TAG_W-1:0] tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      tok_q  <= token_valid_i;
      resp_q <= is_response_i;
      len_q  <= frame_bytes_i;
      tag_q  <= record_tag_i;
    end
  end

  // control state
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [BW-1:0]   buf_q, buf_d;
  logic            open_q, open_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
      buf_q    <= '0;
      open_q   <= 1'b1;
    end else if (cmd_i.exec) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      buf_q    <= buf_d;
      open_q   <= open_d;
    end
  end

  // record store; head is fetched when the word is taken
  bbaf_pkg::rec_t mem_q [DEPTH];
  bbaf_pkg::rec_t head_q;
  logic           mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_ptr_q] <= '{tag: tag_q, is_resp: resp_q, bytes: len_q};
    if (cmd_i.load) head_q <= mem_q[rd_ptr_q];
  end

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // admission checks
  logic                         shape_ok;
  logic [bbaf_pkg::LIMIT_W-1:0] lim_eff;
  logic                         full;
  logic [BW-1:0]                room;
  logic                         over;

  always_comb begin
    shape_ok = tok_q && (resp_q ? (len_q != '0) : (len_q == '0));
    lim_eff  = (entry_limit_q == '0) ? bbaf_pkg::LIMIT_W'(1) : entry_limit_q;
    full     = (CmpW'(cnt_q) >= CmpW'(lim_eff)) || (cnt_q == CntW'(DEPTH));
    room     = (byte_capacity_q > buf_q) ? byte_capacity_q - buf_q : '0;
    over     = BW'(len_q) > room;
  end

  bbaf_pkg::status_e status_d;
  logic              pop_d;
  logic              wake_d;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    buf_d    = buf_q;
    open_d   = open_q;
    status_d = bbaf_pkg::ST_OK;
    pop_d    = 1'b0;
    wake_d   = 1'b0;
    mem_we   = 1'b0;
    unique case (cmd_q)
      bbaf_pkg::CMD_POST: begin
        if (!shape_ok)                 status_d = bbaf_pkg::ST_BAD_SHAPE;
        else if (len_q > max_record_q) status_d = bbaf_pkg::ST_TOO_LARGE;
        else if (!open_q)              status_d = bbaf_pkg::ST_CLOSED;
        else if (full)                 status_d = bbaf_pkg::ST_FULL;
        else if (over)                 status_d = bbaf_pkg::ST_OVER;
        else begin
          mem_we   = cmd_i.exec;
          wr_ptr_d = ptr_inc(wr_ptr_q);
          cnt_d    = cnt_q + 1'b1;
          buf_d    = buf_q + BW'(len_q);
          wake_d   = 1'b1;
        end
      end
      bbaf_pkg::CMD_POP: begin
        if (cnt_q == '0) begin
          status_d = bbaf_pkg::ST_EMPTY;
        end else begin
          rd_ptr_d = ptr_inc(rd_ptr_q);
          cnt_d    = cnt_q - 1'b1;
          buf_d    = (buf_q >= BW'(head_q.bytes)) ? buf_q - BW'(head_q.bytes) : '0;
          pop_d    = 1'b1;
        end
      end
      bbaf_pkg::CMD_CLOSE: begin
        // write pointer always sits count entries past the read pointer
        open_d   = 1'b0;
        rd_ptr_d = wr_ptr_q;
        cnt_d    = '0;
        buf_d    = '0;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o          <= status_d;
      pop_valid_o       <= pop_d;
      out_tag_o         <= pop_d ? head_q.tag : '0;
      out_is_response_o <= pop_d ? head_q.is_resp : 1'b0;
      out_bytes_o       <= pop_d ? head_q.bytes : '0;
      wake_o            <= wake_d;
      entries_now_o     <= cnt_d;
      bytes_held_o      <= buf_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/byte_budget_admission_fifo.sv =====
// ----------------------------------------------------------------------------
// byte_budget_admission_fifo: ring FIFO of records with slot and byte limits
// Sequencing: a taken command is latched in IDLE and run in EXEC, where the result
// register loads once it is free; no new command is taken until the last one has run,
// so a result word that is not taken holds back the next command.
// Reset: async active low; empty, open, limits back to 16 / 65536 / 16384.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_budget_admission_fifo #(
  parameter int unsigned DEPTH = bbaf_pkg::DEPTH_DEF,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic [bbaf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bbaf_pkg::CFG_W-1:0]     cfg_data_i,
  // command and result channels
  bbaf_in_if.sink                             in_if,
  bbaf_out_if.source                          out_if
);

  // Controller only sequences: IDLE takes a command word and fetches the
  // head record from the store; EXEC runs the command once the result
  // register is free (empty, or being drained this cycle).
  bbaf_pkg::ctrl_cmd_t cmd;

  bbaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  // Datapath: store, pointers, counts, the priority chain of post checks
  // (shape, size, closed, full, budget) and the result register.
  bbaf_dp #(
    .DEPTH (DEPTH),
    .CntW  (CntW)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .command_i         (in_if.command),
    .token_valid_i     (in_if.token_valid),
    .is_response_i     (in_if.is_response),
    .frame_bytes_i     (in_if.frame_bytes),
    .record_tag_i      (in_if.record_tag),
    .status_o          (out_if.status),
    .pop_valid_o       (out_if.pop_valid),
    .out_tag_o         (out_if.out_tag),
    .out_is_response_o (out_if.out_is_response),
    .out_bytes_o       (out_if.out_bytes),
    .wake_o            (out_if.wake),
    .entries_now_o     (out_if.entries_now),
    .bytes_held_o      (out_if.bytes_held)
  );

endmodule

`default_nettype wire

// ===== hdl/bbaf_checker.sv =====
// ----------------------------------------------------------------------------
// bbaf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_budget_admission_fifo_defines.svh"

module bbaf_checker #(
  parameter int unsigned DEPTH = bbaf_pkg::DEPTH_DEF,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [bbaf_pkg::STAT_W-1:0]   status_i,
  input wire logic                          pop_valid_i,
  input wire logic [bbaf_pkg::TAG_W-1:0]    out_tag_i,
  input wire logic                          wake_i,
  input wire logic [CntW-1:0]               entries_now_i
);

  // an accepted post is always reported ok
  `BBAF_ASSERT_NOW(a_wake_ok, out_valid_i && wake_i, status_i == bbaf_pkg::ST_OK)

  // a popped record is ok and never a wake
  `BBAF_ASSERT_NOW(a_pop_ok, out_valid_i && pop_valid_i,
                   status_i == bbaf_pkg::ST_OK && !wake_i)

  // occupancy never beyond the store depth
  `BBAF_ASSERT_NOW(a_cnt_max, out_valid_i, entries_now_i <= CntW'(DEPTH))

  // stalled result holds
  `BBAF_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(status_i) && $stable(out_tag_i))

endmodule

bind byte_budget_admission_fifo bbaf_checker #(
  .DEPTH (DEPTH),
  .CntW  (CntW)
) u_bbaf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .status_i      (out_if.status),
  .pop_valid_i   (out_if.pop_valid),
  .out_tag_i     (out_if.out_tag),
  .wake_i        (out_if.wake),
  .entries_now_i (out_if.entries_now)
);

`default_nettype wire
